[hdl/pid_controller_antiwindup_macros.svh]
// Assertion helpers shared by the controller modules.
// Each macro expects clk and rst_n in scope.
`ifndef PID_CONTROLLER_ANTIWINDUP_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_MACROS_SVH

// Same-cycle implication.
`define PCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pca_pkg.sv]
`timescale 1ns / 1ps

package pca_pkg;

  // Sensor range defaults.
  localparam int SENSOR_LOW      = 0;
  localparam int SENSOR_HIGH_DEF = 4095;

  // Datapath widths.
  localparam int SUM_W     = 54;
  localparam int MAG_W     = 37;
  localparam int DVD_W     = 50;
  localparam int DSR_W     = 24;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_GAIN_P   = 3'd1;
  localparam logic [2:0] REG_GAIN_I   = 3'd2;
  localparam logic [2:0] REG_GAIN_D   = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;
  localparam logic [2:0] REG_ZERO     = 3'd5;
  localparam logic [2:0] REG_FLOOR    = 3'd6;
  localparam logic [2:0] REG_CEILING  = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_ACC_P,
    OP_MUL_GT,
    OP_MUL_I,
    OP_ACC_I,
    OP_MUL_D,
    OP_DIVD,
    OP_ACC_D,
    OP_MAG,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_DIVF,
    OP_FINAL
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_ACC_P,
    ST_MUL_GT,
    ST_MUL_I,
    ST_ACC_I,
    ST_MUL_D,
    ST_DIVD,
    ST_DIVD_WAIT,
    ST_ACC_D,
    ST_MAG,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_DIVF,
    ST_DIVF_WAIT,
    ST_FINAL
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

[hdl/pid_controller_antiwindup.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_sensor_sample (12 bit)
// out      output     out_valid/out_stall  out_drive_value, out_error_value,
//                                          out_integral_value, out_drive_clamped
// cfg      input      cfg_valid/cfg_ready  cfg_index (3 bit), cfg_data (16 bit)
//
// Each word runs through 12 multiply, accumulate, load and output steps and two
// divisions, each a start step and a wait on the shared radix-4 divider. A new
// word is taken only once the sequence of the last has returned to idle.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// integrator and last error, and empties the output word.
// A stalled output word holds; the next input word is taken while it waits,
// and its result stays in the final step until the output register frees.

module pid_controller_antiwindup #(
  parameter int SENSOR_HIGH = pca_pkg::SENSOR_HIGH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_sensor_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_drive_value,
  output logic signed [12:0] out_error_value,
  output logic signed [31:0] out_integral_value,
  output logic               out_drive_clamped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pca_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Register writes are always taken; the user must send them only while the loop is idle (not enforced here).
  assign cfg_ready = 1'b1;

  // The controller sequences one word through the datapath, one step a state.
  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the registers, loop state, multiplier and divider.
  pca_datapath #(
    .SENSOR_HIGH (SENSOR_HIGH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .sample         (in_sensor_sample),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .drive_value    (out_drive_value),
    .error_value    (out_error_value),
    .integral_value (out_integral_value),
    .drive_clamped  (out_drive_clamped)
  );

endmodule

[hdl/pca_divider.sv]
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_macros.svh"

module pca_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pca_pkg::DVD_W-1:0] dividend,
  input  logic [pca_pkg::DSR_W-1:0] divisor,
  output logic [pca_pkg::DVD_W-1:0] quotient,
  output logic                      done
);
  import pca_pkg::*;

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt, dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W:0]   st1, st2;

  // One restoring step: shift in a bit, subtract when it fits.
  function automatic logic [DSR_W:0] div_step(input logic [DSR_W-1:0] rem,
                                              input logic bit_in,
                                              input logic [DSR_W-1:0] dsr);
    logic [DSR_W:0] r2;
    r2 = {rem, bit_in};
    if (r2 >= {1'b0, dsr}) begin
      div_step = {1'b1, DSR_W'(r2 - {1'b0, dsr})};
    end else begin
      div_step = {1'b0, r2[DSR_W-1:0]};
    end
  endfunction

  always_comb begin
    st1     = div_step(rem_r, quo_r[DVD_W-1], dsr_r);
    st2     = div_step(st1[DSR_W-1:0], quo_r[DVD_W-2], dsr_r);
    quo_nxt = {quo_r[DVD_W-3:0], st1[DSR_W], st2[DSR_W]};
    rem_nxt = st2[DSR_W-1:0];
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = (cnt_r == '0);

  `PCA_ASSERT_NOW(a_no_restart, start, cnt_r == '0, "divider restarted while busy")
  `PCA_ASSERT_NEXT(a_start_busy, start, !done, "divider done right after start")

endmodule

[hdl/pca_datapath.sv]
`timescale 1ns / 1ps

module pca_datapath #(
  parameter int SENSOR_HIGH = pca_pkg::SENSOR_HIGH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pca_pkg::ctl_cmd_t   cmd,
  output pca_pkg::dp_status_t status,
  input  logic [11:0]         sample,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic [11:0]         drive_value,
  output logic signed [12:0]  error_value,
  output logic signed [31:0]  integral_value,
  output logic                drive_clamped
);
  import pca_pkg::*;

  localparam int unsigned DIVISOR    = (SENSOR_HIGH - SENSOR_LOW) * 100;
  localparam logic [16:0] SAMPLE_MAX = 17'(SENSOR_HIGH);
  localparam logic [MAG_W-1:0] MAG_SAT = MAG_W'(1) << (MAG_W - 1);

  // Configuration and loop state.
  logic [11:0]        tgt_r, dz_r, dfl_r, dcl_r;
  logic signed [15:0] gp_r, gi_r, gd_r;
  logic [15:0]        tint_r;
  logic signed [12:0] last_err_r;
  logic signed [31:0] integ_r;

  // Per-word working registers.
  logic signed [12:0] e_r;
  logic signed [13:0] d_r;
  logic [63:0]        prod_r;
  logic               psign_r, nsign_r;
  logic [16:0]        hip_r;
  logic [SUM_W-1:0]   sum_r;
  logic [MAG_W-1:0]   mag_r;

  logic [11:0]        out_drive_r;
  logic signed [12:0] out_err_r;
  logic signed [31:0] out_integ_r;
  logic               out_clamp_r;

  // Combinational terms.
  logic [11:0]        s_cl;
  logic signed [12:0] e_n;
  logic signed [13:0] d_n;
  logic signed [32:0] isum;
  logic signed [31:0] isat, integ_n;
  logic               flip;
  logic [12:0]        e_mag;
  logic [13:0]        d_mag;
  logic [15:0]        gp_mag, gi_mag, gd_mag, t_cl;
  logic [31:0]        integ_mag;
  logic signed [12:0] span;
  logic [12:0]        span_mag;
  logic [11:0]        fac;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic               psign_nxt;
  logic [SUM_W-1:0]   acc_base, acc_add, acc_res, sum_abs;
  logic [MAG_W-1:0]   mag_n;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd, quo;
  logic [DSR_W-1:0]   div_dsr;
  logic               div_done;
  logic [13:0]        q_sat;
  logic [15:0]        delta;
  logic signed [15:0] setting;
  logic [11:0]        drive_n;
  logic               clamp_n;

  always_comb begin
    s_cl = ({5'b0, sample} > SAMPLE_MAX) ? SAMPLE_MAX[11:0] : sample;
    e_n  = $signed({1'b0, tgt_r}) - $signed({1'b0, s_cl});
    d_n  = {e_n[12], e_n} - {last_err_r[12], last_err_r};
    flip = (!last_err_r[12] && last_err_r != '0 && e_n[12]) ||
           (last_err_r[12] && !e_n[12] && e_n != '0);
    isum = {integ_r[31], integ_r} + {{20{e_n[12]}}, e_n};
    if (isum[32] != isum[31]) begin
      isat = isum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      isat = isum[31:0];
    end
    if (gi_r == '0 || e_n == '0) begin
      integ_n = '0;
    end else if (flip) begin
      integ_n = {{19{e_n[12]}}, e_n};
    end else begin
      integ_n = isat;
    end
  end

  always_comb begin
    e_mag     = e_r[12] ? (~e_r + 13'd1) : e_r;
    d_mag     = d_r[13] ? (~d_r + 14'd1) : d_r;
    gp_mag    = gp_r[15] ? (~gp_r + 16'd1) : gp_r;
    gi_mag    = gi_r[15] ? (~gi_r + 16'd1) : gi_r;
    gd_mag    = gd_r[15] ? (~gd_r + 16'd1) : gd_r;
    integ_mag = integ_r[31] ? (~integ_r + 32'd1) : integ_r;
    if (tint_r < 16'd16) begin
      t_cl = 16'd16;
    end else if (tint_r > 16'd32768) begin
      t_cl = 16'd32768;
    end else begin
      t_cl = tint_r;
    end
    span     = $signed({1'b0, dcl_r}) - $signed({1'b0, dz_r});
    span_mag = span[12] ? (~span + 13'd1) : span;
    fac      = span_mag[11:0];
  end

  // Shared 32 x 32 multiplier.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    psign_nxt = psign_r;
    case (cmd.op)
      OP_MUL_P: begin
        mul_a     = {16'b0, gp_mag};
        mul_b     = {19'b0, e_mag};
        psign_nxt = gp_r[15] ^ e_r[12];
      end
      OP_MUL_GT: begin
        mul_a = {16'b0, gi_mag};
        mul_b = {16'b0, t_cl};
      end
      OP_MUL_I: begin
        mul_a     = prod_r[31:0];
        mul_b     = integ_mag;
        psign_nxt = gi_r[15] ^ integ_r[31];
      end
      OP_MUL_D: begin
        mul_a     = {16'b0, gd_mag};
        mul_b     = {18'b0, d_mag};
        psign_nxt = gd_r[15] ^ d_r[13];
      end
      OP_MUL_HI: begin
        mul_a = {27'b0, mag_r[MAG_W-1:32]};
        mul_b = {20'b0, fac};
      end
      OP_MUL_LO: begin
        mul_a = mag_r[31:0];
        mul_b = {20'b0, fac};
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Signed accumulation of the three terms.
  always_comb begin
    acc_base = (cmd.op == OP_ACC_P) ? '0 : sum_r;
    case (cmd.op)
      OP_ACC_P: acc_add = prod_r[SUM_W-1:0];
      OP_ACC_I: acc_add = prod_r[63:10];
      default:  acc_add = SUM_W'(quo);
    endcase
    acc_res = psign_r ? (acc_base - acc_add) : (acc_base + acc_add);
    sum_abs = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
    mag_n   = (sum_abs[SUM_W-1:MAG_W-1] != '0) ? MAG_SAT : sum_abs[MAG_W-1:0];
  end

  always_comb begin
    div_start = (cmd.op == OP_DIVD) || (cmd.op == OP_DIVF);
    if (cmd.op == OP_DIVD) begin
      div_dvd = {prod_r[DVD_W-11:0], 10'b0};
      div_dsr = DSR_W'(t_cl);
    end else begin
      div_dvd = DVD_W'({hip_r, 32'b0}) + DVD_W'(prod_r[43:0]);
      div_dsr = DSR_W'(DIVISOR);
    end
  end

  pca_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (quo),
    .done     (div_done)
  );

  assign status.div_done = div_done;

  // Final scaling result, offset and clamp.
  always_comb begin
    q_sat   = (quo[DVD_W-1:13] != '0) ? 14'd8192 : {1'b0, quo[12:0]};
    delta   = nsign_r ? (~{2'b0, q_sat} + 16'd1) : {2'b0, q_sat};
    setting = $signed({4'b0, dz_r}) + $signed(delta);
    clamp_n = 1'b1;
    if (setting < $signed({4'b0, dfl_r})) begin
      drive_n = dfl_r;
    end else if (setting > $signed({4'b0, dcl_r})) begin
      drive_n = dcl_r;
    end else begin
      drive_n = setting[11:0];
      clamp_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r      <= 12'd0;
      gp_r       <= '0;
      gi_r       <= '0;
      gd_r       <= '0;
      tint_r     <= 16'd16;
      dz_r       <= 12'd2048;
      dfl_r      <= 12'd0;
      dcl_r      <= 12'd4095;
      last_err_r <= '0;
      integ_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET:   tgt_r  <= cfg_data[11:0];
          REG_GAIN_P:   gp_r   <= cfg_data;
          REG_GAIN_I:   gi_r   <= cfg_data;
          REG_GAIN_D:   gd_r   <= cfg_data;
          REG_INTERVAL: tint_r <= cfg_data;
          REG_ZERO:     dz_r   <= cfg_data[11:0];
          REG_FLOOR:    dfl_r  <= cfg_data[11:0];
          REG_CEILING:  dcl_r  <= cfg_data[11:0];
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        last_err_r <= e_n;
        integ_r    <= integ_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        e_r <= e_n;
        d_r <= d_n;
      end
      OP_MUL_P, OP_MUL_I, OP_MUL_D: begin
        prod_r  <= mul_p;
        psign_r <= psign_nxt;
      end
      OP_MUL_GT, OP_MUL_LO: prod_r <= mul_p;
      OP_MUL_HI:            hip_r  <= mul_p[16:0];
      OP_ACC_P, OP_ACC_I, OP_ACC_D: sum_r <= acc_res;
      OP_MAG: begin
        mag_r   <= mag_n;
        nsign_r <= sum_r[SUM_W-1] ^ span[12];
      end
      OP_FINAL: begin
        out_drive_r <= drive_n;
        out_err_r   <= e_r;
        out_integ_r <= integ_r;
        out_clamp_r <= clamp_n;
      end
      default: begin
      end
    endcase
  end

  assign drive_value    = out_drive_r;
  assign error_value    = out_err_r;
  assign integral_value = out_integ_r;
  assign drive_clamped  = out_clamp_r;

endmodule

[hdl/pca_ctrl.sv]
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_macros.svh"

module pca_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pca_pkg::ctl_cmd_t   cmd,
  input  pca_pkg::dp_status_t status
);
  import pca_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       blocked, fire;

  assign blocked = out_valid_r && out_stall;
  assign fire    = (state_r == ST_FINAL) && !blocked;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = fire || blocked;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_MUL_P;
      ST_MUL_P:     state_nxt = ST_ACC_P;
      ST_ACC_P:     state_nxt = ST_MUL_GT;
      ST_MUL_GT:    state_nxt = ST_MUL_I;
      ST_MUL_I:     state_nxt = ST_ACC_I;
      ST_ACC_I:     state_nxt = ST_MUL_D;
      ST_MUL_D:     state_nxt = ST_DIVD;
      ST_DIVD:      state_nxt = ST_DIVD_WAIT;
      ST_DIVD_WAIT: if (status.div_done) state_nxt = ST_ACC_D;
      ST_ACC_D:     state_nxt = ST_MAG;
      ST_MAG:       state_nxt = ST_MUL_HI;
      ST_MUL_HI:    state_nxt = ST_MUL_LO;
      ST_MUL_LO:    state_nxt = ST_DIVF;
      ST_DIVF:      state_nxt = ST_DIVF_WAIT;
      ST_DIVF_WAIT: if (status.div_done) state_nxt = ST_FINAL;
      ST_FINAL:     if (!blocked) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      ST_IDLE:   if (in_valid) cmd.op = OP_LOAD;
      ST_MUL_P:  cmd.op = OP_MUL_P;
      ST_ACC_P:  cmd.op = OP_ACC_P;
      ST_MUL_GT: cmd.op = OP_MUL_GT;
      ST_MUL_I:  cmd.op = OP_MUL_I;
      ST_ACC_I:  cmd.op = OP_ACC_I;
      ST_MUL_D:  cmd.op = OP_MUL_D;
      ST_DIVD:   cmd.op = OP_DIVD;
      ST_ACC_D:  cmd.op = OP_ACC_D;
      ST_MAG:    cmd.op = OP_MAG;
      ST_MUL_HI: cmd.op = OP_MUL_HI;
      ST_MUL_LO: cmd.op = OP_MUL_LO;
      ST_DIVF:   cmd.op = OP_DIVF;
      ST_FINAL:  if (!blocked) cmd.op = OP_FINAL;
      ST_DIVD_WAIT, ST_DIVF_WAIT: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `PCA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != ST_IDLE,
                   "accepted word did not start the sequence")
  `PCA_ASSERT_NEXT(a_final_hold, state_r == ST_FINAL && blocked, state_r == ST_FINAL,
                   "result lost while the output word was stalled")
  `PCA_ASSERT_NEXT(a_final_fire, fire, out_valid_r && state_r == ST_IDLE,
                   "finished result not presented")

endmodule
